// ----- rtl/core/stkfl_pkg.sv -----
//------------------------------------------------------------------------------
// stkfl_pkg
// shared types and constants of the stk500 flash loader parser
//------------------------------------------------------------------------------
`default_nettype none
package stkfl_pkg;

    localparam int PAGE_BYTES = 256;
    localparam int PAGE_AW    = $clog2(PAGE_BYTES);

    localparam logic [1:0] OP_HOST  = 2'd0;
    localparam logic [1:0] OP_RDATA = 2'd1;
    localparam logic [1:0] OP_READY = 2'd2;

    localparam logic [2:0] K_HOST   = 3'd0;
    localparam logic [2:0] K_ERASE  = 3'd1;
    localparam logic [2:0] K_PSTART = 3'd2;
    localparam logic [2:0] K_PBYTE  = 3'd3;
    localparam logic [2:0] K_READ   = 3'd4;
    localparam logic [2:0] K_ABORT  = 3'd5;
    localparam logic [2:0] K_LEAVE  = 3'd6;

    localparam logic [1:0] CFG_MAJOR = 2'd0;
    localparam logic [1:0] CFG_MINOR = 2'd1;
    localparam logic [1:0] CFG_SIG   = 2'd2;

    localparam logic [7:0] EOP_BYTE     = 8'h20;
    localparam logic [7:0] REPLY_INSYNC = 8'h14;
    localparam logic [7:0] REPLY_OK     = 8'h10;
    localparam logic [7:0] REPLY_FAILED = 8'h11;
    localparam logic [7:0] REPLY_UNKNOWN = 8'h03;
    localparam logic [7:0] CMD_GET_PARAM = 8'h41;
    localparam logic [7:0] CMD_SET_DEV   = 8'h42;
    localparam logic [7:0] CMD_SET_DEV_X = 8'h45;
    localparam logic [7:0] CMD_LEAVE     = 8'h51;
    localparam logic [7:0] CMD_LOAD_ADDR = 8'h55;
    localparam logic [7:0] CMD_UNIVERSAL = 8'h56;
    localparam logic [7:0] CMD_PROG_PAGE = 8'h64;
    localparam logic [7:0] CMD_READ_PAGE = 8'h74;
    localparam logic [7:0] CMD_READ_SIGN = 8'h75;
    localparam logic [7:0] OP_LOAD_EXT   = 8'h4D;
    localparam logic [7:0] PARAM_MAJOR   = 8'h81;
    localparam logic [7:0] PARAM_MINOR   = 8'h82;
    localparam logic [7:0] DEST_EEPROM   = 8'h45;
    localparam logic [8:0] SKIP_SET_DEV  = 9'd20;
    localparam logic [8:0] SKIP_SET_DEVX = 9'd5;

    localparam int MAX_RES = 5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [23:0] flash_address;
        logic [8:0]  transfer_length;
        logic        last_of_run;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/stkfl_ram.sv -----
//------------------------------------------------------------------------------
// stkfl_ram
// generic ram with one write port and one registered read port
//------------------------------------------------------------------------------
`default_nettype none
module stkfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/stkfl_out_fifo.sv -----
//------------------------------------------------------------------------------
// stkfl_out_fifo
// burst queue: takes up to five result items at once and, while i_ready is high, hands out one per cycle
//------------------------------------------------------------------------------
`default_nettype none
module stkfl_out_fifo (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  wire  [2:0]                 i_count,
    input  stkfl_pkg::t_result         i_items [stkfl_pkg::MAX_RES],
    output logic                       o_empty,
    output logic                       o_room,
    output logic                       o_valid,
    input  wire                        i_ready,
    output stkfl_pkg::t_result         o_item
);
    localparam int DEPTH = 8;
    stkfl_pkg::t_result r_q [DEPTH];
    logic [2:0] r_rd, r_wr;
    logic [3:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 4'd0);
    assign o_empty = (r_cnt == 4'd0);
    assign o_item  = r_q[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a full burst behind the one being pushed now
    assign o_room  = ((r_cnt + (i_push ? {1'b0, i_count} : 4'd0)) <= 4'd3);

    always_comb begin
        n_cnt = r_cnt - {3'd0, pop} + (i_push ? {1'b0, i_count} : 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (pop) r_rd <= r_rd + 3'd1;
            if (i_push) r_wr <= r_wr + i_count;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            for (int k = 0; k < stkfl_pkg::MAX_RES; k++) begin
                if (3'(k) < i_count) r_q[r_wr + 3'(k)] <= i_items[k];
            end
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt <= 4'd3)) else $error("queue overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd8) else $error("count out of range");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> (r_cnt == $past(r_cnt) - 4'd1)) else $error("pop count");
endmodule
`default_nettype wire

// ----- rtl/core/stk500_flash_loader_parser_core.sv -----
//------------------------------------------------------------------------------
// stk500_flash_loader_parser_core
// stk500 v1 command parser driving an external flash
//------------------------------------------------------------------------------
// usage:
//   input channel (i_valid/o_ready): op and data byte. op 0 is a host byte,
//   op 1 a byte read back from flash, op 2 a ready pulse for the next program
//   byte. each item is parsed into 0 to 5 result items.
//   output channel (o_valid/i_ready): results leave an 8 entry queue one per
//   cycle while i_ready is high; each item's last one has o_last_of_run set.
//   config channel (i_cfg_valid/o_cfg_ready): always ready; 0 major,
//   1 minor, 2 signature.
//   path: an accepted item passes the parse register, then the page read
//   and queue write. throughput: one item per cycle while the queue has
//   room for a full burst; a program data byte read needs the page ram's
//   registered port.
//   reset: synchronous, clears parser state and the queue; the page buffer
//   holds garbage until written. after an abort the block swallows all
//   items until reset. o_ready drops when the queue lacks room for a burst.
//------------------------------------------------------------------------------
`default_nettype none
module stk500_flash_loader_parser_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_op,
    input  wire  [7:0]  i_data_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [23:0] o_flash_address,
    output logic [8:0]  o_transfer_length,
    output logic        o_last_of_run,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    typedef enum logic [3:0] {
        PH_CMD, PH_PARAM, PH_SKIP, PH_ADDR, PH_UNI_OP, PH_UNI_ZERO, PH_UNI_EXT,
        PH_LEN, PH_DEST, PH_DATA, PH_EOP, PH_PROG, PH_READ
    } t_phase;

    localparam int AW = stkfl_pkg::PAGE_AW;

    t_phase r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd, r_ext, n_ext, r_dest, n_dest, r_erased, n_erased;
    logic [8:0]  r_bcnt, n_bcnt;
    logic [15:0] r_baddr, n_baddr, r_len, n_len;
    logic        r_halted, n_halted;
    logic [7:0]  r_major, r_minor;
    logic [23:0] r_sig;

    // stage 1 registered results, page byte slot filled from ram in stage 2
    stkfl_pkg::t_result r_res [stkfl_pkg::MAX_RES];
    stkfl_pkg::t_result n_res [stkfl_pkg::MAX_RES];
    stkfl_pkg::t_result q_in  [stkfl_pkg::MAX_RES];
    logic [2:0] r_rcnt, n_rcnt;
    logic       r_rvalid, r_pbyte;

    logic        acc, fifo_room, fifo_empty;
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_rdata;
    logic [23:0] faddr;
    stkfl_pkg::t_result out_item;

    assign o_ready     = fifo_room;
    assign acc         = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign faddr       = {r_ext, r_baddr};

    always_comb begin
        stkfl_pkg::t_result e;
        logic [15:0] lw;
        logic [8:0]  bc;
        logic        stop;
        e = '0;
        n_phase = r_phase; n_cmd = r_cmd; n_ext = r_ext; n_dest = r_dest;
        n_erased = r_erased; n_bcnt = r_bcnt; n_baddr = r_baddr; n_len = r_len;
        n_halted = r_halted;
        n_rcnt = 3'd0;
        for (int k = 0; k < stkfl_pkg::MAX_RES; k++) n_res[k] = '0;
        ram_we = 1'b0;
        ram_waddr = r_bcnt[AW-1:0];
        ram_raddr = r_bcnt[AW-1:0];
        lw = r_len; bc = r_bcnt; stop = 1'b0;
        if (acc && !r_halted) begin
            if (i_op == stkfl_pkg::OP_HOST) begin
                unique case (r_phase)
                    PH_CMD: begin
                        n_cmd = i_data_byte;
                        unique case (i_data_byte)
                            stkfl_pkg::CMD_GET_PARAM: n_phase = PH_PARAM;
                            stkfl_pkg::CMD_SET_DEV: begin
                                n_bcnt = stkfl_pkg::SKIP_SET_DEV; n_phase = PH_SKIP;
                            end
                            stkfl_pkg::CMD_SET_DEV_X: begin
                                n_bcnt = stkfl_pkg::SKIP_SET_DEVX; n_phase = PH_SKIP;
                            end
                            stkfl_pkg::CMD_LOAD_ADDR: begin
                                n_bcnt = '0; n_len = '0; n_phase = PH_ADDR;
                            end
                            stkfl_pkg::CMD_UNIVERSAL: n_phase = PH_UNI_OP;
                            stkfl_pkg::CMD_PROG_PAGE, stkfl_pkg::CMD_READ_PAGE: begin
                                n_bcnt = '0; n_len = '0; n_phase = PH_LEN;
                            end
                            default: n_phase = PH_EOP;
                        endcase
                    end
                    PH_PARAM: begin
                        n_len = {8'd0, i_data_byte}; n_phase = PH_EOP;
                    end
                    PH_SKIP: begin
                        bc = (r_bcnt != 9'd0) ? r_bcnt - 9'd1 : r_bcnt;
                        n_bcnt = bc;
                        if (bc == 9'd0) n_phase = PH_EOP;
                    end
                    PH_ADDR: begin
                        lw = r_len | ((r_bcnt < 9'd2) ? {8'd0, i_data_byte}
                                                      : {i_data_byte, 8'd0});
                        n_len = lw;
                        n_bcnt = r_bcnt + 9'd1;
                        if (n_bcnt >= 9'd4) begin
                            n_ext = {r_ext[7:1], lw[15]};
                            n_baddr = {lw[14:0], 1'b0};
                            n_phase = PH_EOP;
                        end
                    end
                    PH_UNI_OP: begin
                        if (i_data_byte == stkfl_pkg::OP_LOAD_EXT) n_phase = PH_UNI_ZERO;
                        else begin
                            n_bcnt = 9'd3; n_phase = PH_SKIP;
                        end
                    end
                    PH_UNI_ZERO: n_phase = PH_UNI_EXT;
                    PH_UNI_EXT: begin
                        n_ext = {i_data_byte[6:0], r_ext[0]};
                        n_bcnt = 9'd1; n_phase = PH_SKIP;
                    end
                    PH_LEN: begin
                        lw = r_len | ((r_bcnt < 9'd2) ? {i_data_byte, 8'd0}
                                                      : {8'd0, i_data_byte});
                        n_len = lw;
                        n_bcnt = r_bcnt + 9'd1;
                        if (n_bcnt >= 9'd4) begin
                            if (lw == 16'd0 || lw > 16'(stkfl_pkg::PAGE_BYTES)) begin
                                e.kind = stkfl_pkg::K_ABORT;
                                n_res[0] = e; n_rcnt = 3'd1;
                                n_halted = 1'b1; n_phase = PH_CMD;
                            end else n_phase = PH_DEST;
                        end
                    end
                    PH_DEST: begin
                        n_dest = i_data_byte; n_bcnt = '0;
                        n_phase = (r_cmd == stkfl_pkg::CMD_PROG_PAGE) ? PH_DATA : PH_EOP;
                    end
                    PH_DATA: begin
                        if (r_bcnt < 9'(stkfl_pkg::PAGE_BYTES)) ram_we = 1'b1;
                        n_bcnt = r_bcnt + 9'd1;
                        if ({7'd0, n_bcnt} >= r_len) n_phase = PH_EOP;
                    end
                    PH_EOP: begin
                        n_phase = PH_CMD;
                        if (i_data_byte != stkfl_pkg::EOP_BYTE) begin
                            e.out_byte = stkfl_pkg::REPLY_FAILED; n_res[0] = e;
                            e = '0; e.kind = stkfl_pkg::K_ABORT; n_res[1] = e;
                            n_rcnt = 3'd2; n_halted = 1'b1;
                        end else begin
                            e.out_byte = stkfl_pkg::REPLY_INSYNC; n_res[0] = e;
                            n_rcnt = 3'd1;
                            unique case (r_cmd)
                                stkfl_pkg::CMD_GET_PARAM: begin
                                    e = '0;
                                    if (r_len[7:0] == stkfl_pkg::PARAM_MINOR)
                                        e.out_byte = r_minor;
                                    else if (r_len[7:0] == stkfl_pkg::PARAM_MAJOR)
                                        e.out_byte = r_major;
                                    else e.out_byte = stkfl_pkg::REPLY_UNKNOWN;
                                    n_res[1] = e; n_rcnt = 3'd2;
                                end
                                stkfl_pkg::CMD_UNIVERSAL: begin
                                    n_res[1] = '0; n_rcnt = 3'd2;
                                end
                                stkfl_pkg::CMD_PROG_PAGE: begin
                                    stop = 1'b1;
                                    if (r_dest == stkfl_pkg::DEST_EEPROM) begin
                                        e = '0; e.kind = stkfl_pkg::K_ABORT;
                                        n_res[1] = e; n_rcnt = 3'd2; n_halted = 1'b1;
                                    end else begin
                                        e = '0; e.kind = stkfl_pkg::K_ERASE;
                                        e.flash_address = faddr;
                                        if (r_baddr == 16'd0 && (r_ext >= 8'd8 ||
                                                !r_erased[r_ext[2:0]])) begin
                                            n_res[1] = e; n_rcnt = 3'd2;
                                            if (r_ext < 8'd8)
                                                n_erased[r_ext[2:0]] = 1'b1;
                                        end
                                        e.kind = stkfl_pkg::K_PSTART;
                                        e.transfer_length = r_len[8:0];
                                        n_res[n_rcnt] = e; n_rcnt = n_rcnt + 3'd1;
                                        n_bcnt = '0; n_phase = PH_PROG;
                                    end
                                end
                                stkfl_pkg::CMD_READ_PAGE: begin
                                    stop = 1'b1;
                                    e = '0; e.kind = stkfl_pkg::K_READ;
                                    e.flash_address = faddr;
                                    e.transfer_length = r_len[8:0];
                                    n_res[1] = e; n_rcnt = 3'd2;
                                    n_bcnt = '0; n_phase = PH_READ;
                                end
                                stkfl_pkg::CMD_READ_SIGN: begin
                                    e = '0;
                                    e.out_byte = r_sig[23:16]; n_res[1] = e;
                                    e.out_byte = r_sig[15:8];  n_res[2] = e;
                                    e.out_byte = r_sig[7:0];   n_res[3] = e;
                                    n_rcnt = 3'd4;
                                end
                                default: ;
                            endcase
                            if (!stop) begin
                                e = '0; e.out_byte = stkfl_pkg::REPLY_OK;
                                n_res[n_rcnt] = e; n_rcnt = n_rcnt + 3'd1;
                                if (r_cmd == stkfl_pkg::CMD_LEAVE) begin
                                    e = '0; e.kind = stkfl_pkg::K_LEAVE;
                                    n_res[n_rcnt] = e; n_rcnt = n_rcnt + 3'd1;
                                end
                            end
                        end
                    end
                    PH_PROG, PH_READ: ;
                    default: n_phase = PH_CMD;
                endcase
            end else if (i_op == stkfl_pkg::OP_RDATA && r_phase == PH_READ) begin
                e.out_byte = i_data_byte; n_res[0] = e; n_rcnt = 3'd1;
                n_bcnt = r_bcnt + 9'd1;
                if ({7'd0, n_bcnt} >= r_len) begin
                    e = '0; e.out_byte = stkfl_pkg::REPLY_OK; n_res[1] = e;
                    n_rcnt = 3'd2; n_phase = PH_CMD;
                end
            end else if (i_op == stkfl_pkg::OP_READY && r_phase == PH_PROG) begin
                e.kind = stkfl_pkg::K_PBYTE; e.flash_address = faddr;
                e.transfer_length = r_len[8:0];
                n_res[0] = e; n_rcnt = 3'd1;
                n_bcnt = r_bcnt + 9'd1;
                if ({7'd0, n_bcnt} >= r_len) begin
                    e = '0; e.out_byte = stkfl_pkg::REPLY_OK; n_res[1] = e;
                    n_rcnt = 3'd2; n_phase = PH_CMD;
                end
            end
        end
        if (n_rcnt != 3'd0) n_res[n_rcnt - 3'd1].last_of_run = 1'b1;
    end

    stkfl_ram #(.WIDTH(8), .DEPTH(stkfl_pkg::PAGE_BYTES)) u_page (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD; r_cmd <= '0; r_ext <= '0; r_dest <= '0;
            r_erased <= '0; r_bcnt <= '0; r_baddr <= '0; r_len <= '0;
            r_halted <= 1'b0; r_rvalid <= 1'b0; r_rcnt <= '0; r_pbyte <= 1'b0;
            r_major <= 8'd6; r_minor <= 8'd2; r_sig <= 24'h1E9801;
        end else begin
            r_phase <= n_phase; r_cmd <= n_cmd; r_ext <= n_ext; r_dest <= n_dest;
            r_erased <= n_erased; r_bcnt <= n_bcnt; r_baddr <= n_baddr; r_len <= n_len;
            r_halted <= n_halted;
            r_rvalid <= acc;
            r_rcnt <= n_rcnt;
            r_pbyte <= (n_rcnt != 3'd0) && (n_res[0].kind == stkfl_pkg::K_PBYTE);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    stkfl_pkg::CFG_MAJOR: r_major <= i_cfg_data[7:0];
                    stkfl_pkg::CFG_MINOR: r_minor <= i_cfg_data[7:0];
                    stkfl_pkg::CFG_SIG:   r_sig   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_res <= n_res;
    end

    always_comb begin
        for (int k = 0; k < stkfl_pkg::MAX_RES; k++) q_in[k] = r_res[k];
        if (r_pbyte) q_in[0].out_byte = ram_rdata;
    end

    stkfl_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rvalid && r_rcnt != 3'd0),
        .i_count (r_rcnt),
        .i_items (q_in),
        .o_empty (fifo_empty),
        .o_room  (fifo_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (out_item)
    );

    assign o_kind            = out_item.kind;
    assign o_out_byte        = out_item.out_byte;
    assign o_flash_address   = out_item.flash_address;
    assign o_transfer_length = out_item.transfer_length;
    assign o_last_of_run     = out_item.last_of_run;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted) else $error("halt cleared");
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (n_rcnt == 3'd0)) else $error("result while halted");
    a_burst_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_rcnt <= 3'd5) else $error("burst too long");
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_empty |-> !o_valid) else $error("valid from empty queue");
endmodule
`default_nettype wire

// ----- tb/sv/stk500_flash_loader_parser_core_tb.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// stk500_flash_loader_parser_core_tb
// drives stk500 command streams into the parser and checks every reply item
// against a cycle-free predictor: directed commands first, then random
// well-formed packets mixed with ignored noise, under several idle and stall
// mixes with register writes in between, and a final abort that halts the block
//------------------------------------------------------------------------------
`default_nettype none
module stk500_flash_loader_parser_core_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 380;

    typedef enum int {
        PH_CMD, PH_PARAM, PH_SKIP, PH_ADDR, PH_UNI_OP, PH_UNI_ZERO, PH_UNI_EXT,
        PH_LEN, PH_DEST, PH_DATA, PH_EOP, PH_PROG, PH_READ
    } t_parse_phase;

    class t_scoreboard;
        logic [7:0]   sw_major, sw_minor;
        logic [23:0]  signature;
        t_parse_phase phase;
        logic [7:0]   cmd, ext_addr, dest, erased;
        logic [15:0]  byte_addr, word;
        int           count;
        bit           halted;
        logic [7:0]   page [stkfl_pkg::PAGE_BYTES];
        stkfl_pkg::t_result pending_replies[$];
        int           errors;

        function new();
            sw_major  = 8'd6;
            sw_minor  = 8'd2;
            signature = 24'h1E9801;
            phase     = PH_CMD;
            cmd = '0; ext_addr = '0; dest = '0; erased = '0;
            byte_addr = '0; word = '0; count = 0; halted = 1'b0; errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            if (idx == stkfl_pkg::CFG_MAJOR) sw_major = val[7:0];
            else if (idx == stkfl_pkg::CFG_MINOR) sw_minor = val[7:0];
            else if (idx == stkfl_pkg::CFG_SIG) signature = val;
        endfunction

        function void add(logic [2:0] k, logic [7:0] ob, logic [23:0] a, logic [8:0] len);
            stkfl_pkg::t_result r;
            r.kind = k; r.out_byte = ob; r.flash_address = a;
            r.transfer_length = len; r.last_of_run = 1'b0;
            pending_replies.push_back(r);
        endfunction

        function logic [23:0] faddr();
            return {ext_addr, byte_addr};
        endfunction

        function void abort_run();
            add(stkfl_pkg::K_ABORT, '0, '0, '0);
            halted = 1'b1;
            phase = PH_CMD;
        endfunction

        function void skip(int n);
            count = n;
            phase = PH_SKIP;
        endfunction

        function void end_packet(logic [7:0] b);
            logic [7:0] blk;
            if (b != stkfl_pkg::EOP_BYTE) begin
                add(stkfl_pkg::K_HOST, stkfl_pkg::REPLY_FAILED, '0, '0);
                abort_run();
                return;
            end
            add(stkfl_pkg::K_HOST, stkfl_pkg::REPLY_INSYNC, '0, '0);
            case (cmd)
                stkfl_pkg::CMD_GET_PARAM: begin
                    if (word[7:0] == stkfl_pkg::PARAM_MINOR)
                        add(stkfl_pkg::K_HOST, sw_minor, '0, '0);
                    else if (word[7:0] == stkfl_pkg::PARAM_MAJOR)
                        add(stkfl_pkg::K_HOST, sw_major, '0, '0);
                    else add(stkfl_pkg::K_HOST, stkfl_pkg::REPLY_UNKNOWN, '0, '0);
                end
                stkfl_pkg::CMD_UNIVERSAL: add(stkfl_pkg::K_HOST, 8'h00, '0, '0);
                stkfl_pkg::CMD_PROG_PAGE: begin
                    if (dest == stkfl_pkg::DEST_EEPROM) begin
                        abort_run();
                        return;
                    end
                    if (byte_addr == 0) begin
                        if (ext_addr < 8) begin
                            blk = 8'd1 << ext_addr;
                            if ((erased & blk) == 0) begin
                                add(stkfl_pkg::K_ERASE, '0, faddr(), '0);
                                erased = erased | blk;
                            end
                        end else begin
                            add(stkfl_pkg::K_ERASE, '0, faddr(), '0);
                        end
                    end
                    add(stkfl_pkg::K_PSTART, '0, faddr(), word[8:0]);
                    count = 0;
                    phase = PH_PROG;
                    return;
                end
                stkfl_pkg::CMD_READ_PAGE: begin
                    add(stkfl_pkg::K_READ, '0, faddr(), word[8:0]);
                    count = 0;
                    phase = PH_READ;
                    return;
                end
                stkfl_pkg::CMD_READ_SIGN: begin
                    add(stkfl_pkg::K_HOST, signature[23:16], '0, '0);
                    add(stkfl_pkg::K_HOST, signature[15:8], '0, '0);
                    add(stkfl_pkg::K_HOST, signature[7:0], '0, '0);
                end
                default: ;
            endcase
            add(stkfl_pkg::K_HOST, stkfl_pkg::REPLY_OK, '0, '0);
            if (cmd == stkfl_pkg::CMD_LEAVE) add(stkfl_pkg::K_LEAVE, '0, '0, '0);
            phase = PH_CMD;
        endfunction

        function void host_byte(logic [7:0] b);
            case (phase)
                PH_CMD: begin
                    cmd = b;
                    if (b == stkfl_pkg::CMD_GET_PARAM) phase = PH_PARAM;
                    else if (b == stkfl_pkg::CMD_SET_DEV) skip(20);
                    else if (b == stkfl_pkg::CMD_SET_DEV_X) skip(5);
                    else if (b == stkfl_pkg::CMD_LOAD_ADDR) begin
                        count = 0; word = '0; phase = PH_ADDR;
                    end else if (b == stkfl_pkg::CMD_UNIVERSAL) phase = PH_UNI_OP;
                    else if (b == stkfl_pkg::CMD_PROG_PAGE ||
                             b == stkfl_pkg::CMD_READ_PAGE) begin
                        count = 0; word = '0; phase = PH_LEN;
                    end else phase = PH_EOP;
                end
                PH_PARAM: begin
                    word = {8'h00, b};
                    phase = PH_EOP;
                end
                PH_SKIP: begin
                    if (count > 0) count--;
                    if (count == 0) phase = PH_EOP;
                end
                PH_ADDR: begin
                    if (count < 2) word = word | {8'h00, b};
                    else word = word | {b, 8'h00};
                    count++;
                    if (count >= 4) begin
                        ext_addr[0] = word[15];
                        byte_addr = word << 1;
                        phase = PH_EOP;
                    end
                end
                PH_UNI_OP: begin
                    if (b == stkfl_pkg::OP_LOAD_EXT) phase = PH_UNI_ZERO;
                    else skip(3);
                end
                PH_UNI_ZERO: phase = PH_UNI_EXT;
                PH_UNI_EXT: begin
                    ext_addr = {b[6:0], ext_addr[0]};
                    skip(1);
                end
                PH_LEN: begin
                    if (count < 2) word = word | {b, 8'h00};
                    else word = word | {8'h00, b};
                    count++;
                    if (count >= 4) begin
                        if (word == 0 || word > stkfl_pkg::PAGE_BYTES) abort_run();
                        else phase = PH_DEST;
                    end
                end
                PH_DEST: begin
                    dest = b;
                    count = 0;
                    phase = (cmd == stkfl_pkg::CMD_PROG_PAGE) ? PH_DATA : PH_EOP;
                end
                PH_DATA: begin
                    if (count < stkfl_pkg::PAGE_BYTES) page[count] = b;
                    count++;
                    if (count >= word) phase = PH_EOP;
                end
                PH_EOP: end_packet(b);
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] b);
            int n0;
            n0 = pending_replies.size();
            if (halted) return;
            if (op == stkfl_pkg::OP_HOST) begin
                host_byte(b);
            end else if (op == stkfl_pkg::OP_RDATA && phase == PH_READ) begin
                add(stkfl_pkg::K_HOST, b, '0, '0);
                count++;
                if (count >= word) begin
                    add(stkfl_pkg::K_HOST, stkfl_pkg::REPLY_OK, '0, '0);
                    phase = PH_CMD;
                end
            end else if (op == stkfl_pkg::OP_READY && phase == PH_PROG) begin
                add(stkfl_pkg::K_PBYTE, page[count], faddr(), word[8:0]);
                count++;
                if (count >= word) begin
                    add(stkfl_pkg::K_HOST, stkfl_pkg::REPLY_OK, '0, '0);
                    phase = PH_CMD;
                end
            end
            if (pending_replies.size() > n0)
                pending_replies[pending_replies.size() - 1].last_of_run = 1'b1;
        endfunction

        function void check_reply(stkfl_pkg::t_result got);
            stkfl_pkg::t_result exp;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending_replies.pop_front();
            if (got.kind !== exp.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind);
                errors++;
            end
            if (got.out_byte !== exp.out_byte) begin
                $display("%0t: out_byte exp %h got %h", $time, exp.out_byte, got.out_byte);
                errors++;
            end
            if (got.flash_address !== exp.flash_address) begin
                $display("%0t: flash_address exp %h got %h", $time,
                         exp.flash_address, got.flash_address);
                errors++;
            end
            if (got.transfer_length !== exp.transfer_length) begin
                $display("%0t: transfer_length exp %0d got %0d", $time,
                         exp.transfer_length, got.transfer_length);
                errors++;
            end
            if (got.last_of_run !== exp.last_of_run) begin
                $display("%0t: last_of_run exp %b got %b", $time,
                         exp.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_valid, i_ready, i_cfg_valid;
    logic [1:0]  i_op, i_cfg_index;
    logic [7:0]  i_data_byte;
    logic [23:0] i_cfg_data;
    logic        o_ready, o_valid, o_last_of_run, o_cfg_ready;
    logic [2:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [23:0] o_flash_address;
    logic [8:0]  o_transfer_length;

    t_scoreboard board;
    int items_sent;
    int snd_idle_pct, rcv_stall_pct;
    bit noise_on;

    stk500_flash_loader_parser_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_op(i_op), .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_ready(i_ready), .o_kind(o_kind), .o_out_byte(o_out_byte),
        .o_flash_address(o_flash_address), .o_transfer_length(o_transfer_length),
        .o_last_of_run(o_last_of_run),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        stkfl_pkg::t_result got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.kind = o_kind;
                got.out_byte = o_out_byte;
                got.flash_address = o_flash_address;
                got.transfer_length = o_transfer_length;
                got.last_of_run = o_last_of_run;
                board.check_reply(got);
            end
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_item(op, b);
        items_sent++;
    endtask

    task automatic host(input logic [7:0] b);
        send_item(stkfl_pkg::OP_HOST, b);
    endtask

    // ignored items: unused op, host bytes, flash bytes and ready pulses out of phase
    task automatic maybe_noise(input logic [1:0] op);
        if (noise_on && $urandom_range(99) < 10) send_item(op, 8'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one field byte sent as two bytes that or together
    task automatic send_pair(input logic [7:0] v);
        logic [7:0] r, a;
        r = 8'($urandom);
        a = v & r;
        host(a);
        host((v & ~r) | (v & 8'($urandom)));
    endtask

    task automatic cmd_simple(input logic [7:0] c);
        host(c);
        host(stkfl_pkg::EOP_BYTE);
    endtask

    task automatic cmd_param(input logic [7:0] p);
        host(stkfl_pkg::CMD_GET_PARAM);
        host(p);
        host(stkfl_pkg::EOP_BYTE);
    endtask

    task automatic cmd_skip(input logic [7:0] c, input int n);
        host(c);
        repeat (n) host(8'($urandom));
        host(stkfl_pkg::EOP_BYTE);
    endtask

    task automatic cmd_universal(input bit load_ext, input logic [7:0] x);
        logic [7:0] uop;
        host(stkfl_pkg::CMD_UNIVERSAL);
        if (load_ext) begin
            host(stkfl_pkg::OP_LOAD_EXT);
            host(8'($urandom));
            host(x);
            host(8'($urandom));
        end else begin
            do uop = 8'($urandom); while (uop == stkfl_pkg::OP_LOAD_EXT);
            host(uop);
            repeat (3) host(8'($urandom));
        end
        host(stkfl_pkg::EOP_BYTE);
    endtask

    task automatic cmd_load_addr(input logic [15:0] w);
        host(stkfl_pkg::CMD_LOAD_ADDR);
        send_pair(w[7:0]);
        send_pair(w[15:8]);
        host(stkfl_pkg::EOP_BYTE);
    endtask

    task automatic send_len(input logic [7:0] c, input logic [15:0] len);
        host(c);
        send_pair(len[15:8]);
        send_pair(len[7:0]);
    endtask

    task automatic cmd_prog(input int len);
        logic [7:0] d;
        send_len(stkfl_pkg::CMD_PROG_PAGE, 16'(len));
        do d = 8'($urandom); while (d == stkfl_pkg::DEST_EEPROM);
        host(d);
        repeat (len) host(8'($urandom));
        host(stkfl_pkg::EOP_BYTE);
        repeat (len) begin
            maybe_noise(stkfl_pkg::OP_HOST);
            maybe_noise(stkfl_pkg::OP_RDATA);
            send_item(stkfl_pkg::OP_READY, 8'($urandom));
        end
    endtask

    task automatic cmd_read(input int len);
        send_len(stkfl_pkg::CMD_READ_PAGE, 16'(len));
        host(8'($urandom));
        host(stkfl_pkg::EOP_BYTE);
        repeat (len) begin
            maybe_noise(stkfl_pkg::OP_HOST);
            maybe_noise(stkfl_pkg::OP_READY);
            send_item(stkfl_pkg::OP_RDATA, 8'($urandom));
        end
    endtask

    function automatic int rand_len();
        int p;
        p = $urandom_range(99);
        if (p < 80) return $urandom_range(8, 1);
        return $urandom_range(24, 9);
    endfunction

    function automatic logic [7:0] rand_unknown_cmd();
        logic [7:0] c;
        do c = 8'($urandom);
        while (c == stkfl_pkg::CMD_GET_PARAM || c == stkfl_pkg::CMD_SET_DEV ||
               c == stkfl_pkg::CMD_SET_DEV_X || c == stkfl_pkg::CMD_LOAD_ADDR ||
               c == stkfl_pkg::CMD_UNIVERSAL || c == stkfl_pkg::CMD_PROG_PAGE ||
               c == stkfl_pkg::CMD_READ_PAGE);
        return c;
    endfunction

    task automatic random_command();
        int p;
        maybe_noise(OP_UNUSED);
        maybe_noise(stkfl_pkg::OP_RDATA);
        maybe_noise(stkfl_pkg::OP_READY);
        p = $urandom_range(99);
        if (p < 25) cmd_prog(rand_len());
        else if (p < 45) cmd_read(rand_len());
        else if (p < 60) begin
            case ($urandom_range(3))
                0, 1: cmd_load_addr(16'h0000);
                2: cmd_load_addr(16'h8000);
                default: cmd_load_addr(16'($urandom));
            endcase
        end else if (p < 70) begin
            if ($urandom_range(3) != 0) cmd_universal(1'b1, 8'($urandom_range(9)));
            else if ($urandom_range(1)) cmd_universal(1'b1, 8'($urandom));
            else cmd_universal(1'b0, 8'h00);
        end else if (p < 78) begin
            case ($urandom_range(2))
                0: cmd_param(stkfl_pkg::PARAM_MAJOR);
                1: cmd_param(stkfl_pkg::PARAM_MINOR);
                default: cmd_param(8'($urandom));
            endcase
        end else if (p < 83) cmd_simple(stkfl_pkg::CMD_READ_SIGN);
        else if (p < 88) cmd_skip(stkfl_pkg::CMD_SET_DEV, 20);
        else if (p < 92) cmd_skip(stkfl_pkg::CMD_SET_DEV_X, 5);
        else if (p < 95) cmd_simple(stkfl_pkg::CMD_LEAVE);
        else cmd_simple(rand_unknown_cmd());
    endtask

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int ph;
        int directed;
        board = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_op = stkfl_pkg::OP_HOST; i_data_byte = 8'h00;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = stkfl_pkg::CFG_MAJOR; i_cfg_data = 24'h0;
        items_sent = 0; snd_idle_pct = 0; rcv_stall_pct = 0; noise_on = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme register values and every command
        write_reg(stkfl_pkg::CFG_MAJOR, 24'h0000FF);
        write_reg(stkfl_pkg::CFG_MINOR, 24'h000000);
        write_reg(stkfl_pkg::CFG_SIG, 24'hFFFFFF);
        cmd_param(stkfl_pkg::PARAM_MAJOR);
        cmd_param(stkfl_pkg::PARAM_MINOR);
        cmd_param(8'h00);
        cmd_simple(stkfl_pkg::CMD_READ_SIGN);
        cmd_skip(stkfl_pkg::CMD_SET_DEV, 20);
        cmd_skip(stkfl_pkg::CMD_SET_DEV_X, 5);
        cmd_universal(1'b0, 8'h00);
        cmd_universal(1'b1, 8'hFF);
        cmd_load_addr(16'hFFFF);
        cmd_prog(1);
        cmd_read(2);
        cmd_universal(1'b1, 8'h00);
        cmd_load_addr(16'h0000);
        cmd_prog(3);
        cmd_prog(2);
        cmd_simple(stkfl_pkg::CMD_LEAVE);
        cmd_simple(8'hFF);
        wait_drained();
        write_reg(stkfl_pkg::CFG_MAJOR, 24'h000000);
        write_reg(stkfl_pkg::CFG_MINOR, 24'h0000FF);
        write_reg(stkfl_pkg::CFG_SIG, 24'h000000);
        cmd_param(stkfl_pkg::PARAM_MAJOR);
        cmd_param(stkfl_pkg::PARAM_MINOR);
        cmd_simple(stkfl_pkg::CMD_READ_SIGN);
        cmd_load_addr(16'h8000);
        cmd_prog(4);
        directed = items_sent;

        noise_on = 1;
        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_reg(stkfl_pkg::CFG_MAJOR, 24'($urandom_range(255)));
            write_reg(stkfl_pkg::CFG_MINOR, 24'($urandom_range(255)));
            write_reg(stkfl_pkg::CFG_SIG, 24'($urandom));
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 84; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 84; end
                default: begin snd_idle_pct = 35; rcv_stall_pct = 35; end
            endcase
            while (items_sent < directed + (TARGET_ITEMS - directed) * (ph + 1) / 4)
                random_command();
        end

        // one abort halts the block for the rest of the run
        wait_drained();
        case ($urandom_range(3))
            0: begin
                host(stkfl_pkg::CMD_GET_PARAM);
                host(stkfl_pkg::PARAM_MAJOR);
                host(8'($urandom_range(255, 33)));
            end
            1: begin
                send_len(stkfl_pkg::CMD_PROG_PAGE, 16'd1);
                host(stkfl_pkg::DEST_EEPROM);
                host(8'($urandom));
                host(stkfl_pkg::EOP_BYTE);
            end
            2: send_len(stkfl_pkg::CMD_READ_PAGE, 16'd0);
            default: send_len(stkfl_pkg::CMD_PROG_PAGE,
                              16'($urandom_range(16'hFFFF, stkfl_pkg::PAGE_BYTES + 1)));
        endcase
        repeat (10) send_item(2'($urandom), 8'($urandom));
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/stkfl_pkg.sv
rtl/core/stkfl_ram.sv
rtl/core/stkfl_out_fifo.sv
rtl/core/stk500_flash_loader_parser_core.sv
tb/sv/stk500_flash_loader_parser_core_tb.sv
